// ----- sv/assert_macros.svh -----
// Concurrent assertion macros shared by the damping unit RTL.
// Expects clk and rst_n in the scope of each use; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define JKMD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("concurrent check failed");
`define JKMD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define JKMD_ASSERT(lbl, prop)
`define JKMD_NEVER(lbl, cond)
`endif
`endif

// ----- sv/jkmd_pkg.sv -----
// Shared constants and types of the Jackson kernel moment damping unit.
// No dependencies; used by the front, queue, back and top level.
package jkmd_pkg;

    localparam int MAX_MOMENTS  = 4096;
    localparam int MAX_ORBITALS = 256;

    // Row counter holds MAX_MOMENTS itself (it saturates there).
    localparam int ROW_W  = $clog2(MAX_MOMENTS + 1);
    localparam int ORB_W  = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int NORB_W = ORB_W + 1;
    localparam int K_W    = ROW_W + 1;

    // Field and register widths fixed by the interface.
    localparam int ORDER_W = 13;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = 12;

    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);

    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [2:0] {
        REG_KERNEL_ORDER  = 3'd0,
        REG_ORBITAL_COUNT = 3'd1,
        REG_PHI_OVER_PI   = 3'd2,
        REG_COT_TERM      = 3'd3,
        REG_STEP_COS      = 3'd4,
        REG_STEP_SIN      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [ORDER_W-1:0]  kernel_order;
        logic [COUNT_W-1:0]  orbital_count;
        logic [30:0]         phi_over_pi;
        logic [30:0]         cot_term;
        logic signed [31:0]  step_cos;
        logic signed [31:0]  step_sin;
    } cfg_t;

    // One kept moment together with its row bookkeeping.
    typedef struct packed {
        logic signed [31:0]  re;
        logic signed [31:0]  im;
        logic                first;
        logic                orb0;
        logic                row_end;
        logic                last;
        logic [IDX_W-1:0]    index;
        logic [K_W-1:0]      k;
    } q_entry_t;

endpackage

// ----- sv/jkmd_front.sv -----
// Front end: accepts moments, tracks row and orbital, drops truncated rows.
// Depends on jkmd_pkg; feeds jkmd_queue.
module jkmd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jkmd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   moment_re,
    input  logic signed [31:0]   moment_im,
    input  logic                 first_item,
    input  logic                 q_full,
    output logic                 q_push,
    output jkmd_pkg::q_entry_t   q_entry
);
    import jkmd_pkg::*;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ORB_W-1:0]  orb_reg, orb_next;
    logic [ROW_W-1:0]  order_eff;
    logic [NORB_W-1:0] norb_eff;
    logic [ROW_W-1:0]  row_cur;
    logic [ORB_W-1:0]  orb_raw, orb_cur;
    logic              kept, row_end, accept;
    logic [31:0]       ko32, no32;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ko32 = 32'(cfg.kernel_order);
        no32 = 32'(cfg.orbital_count);
        priority if (ko32 == 32'd0)
            order_eff = ROW_W'(1);
        else if (ko32 > 32'(MAX_MOMENTS))
            order_eff = ROW_W'(MAX_MOMENTS);
        else
            order_eff = ROW_W'(ko32);
        priority if (no32 == 32'd0)
            norb_eff = NORB_W'(1);
        else if (no32 > 32'(MAX_ORBITALS))
            norb_eff = NORB_W'(MAX_ORBITALS);
        else
            norb_eff = NORB_W'(no32);

        row_cur = first_item ? '0 : row_reg;
        orb_raw = first_item ? '0 : orb_reg;
        orb_cur = ({1'b0, orb_raw} >= norb_eff) ? '0 : orb_raw;

        kept    = row_cur < order_eff;
        row_end = (NORB_W'({1'b0, orb_cur}) + NORB_W'(1)) >= norb_eff;

        q_push          = accept && kept;
        q_entry.re      = moment_re;
        q_entry.im      = moment_im;
        q_entry.first   = first_item;
        q_entry.orb0    = (orb_cur == '0);
        q_entry.row_end = row_end;
        q_entry.last    = row_end &&
                          ((ROW_W+1)'(row_cur) + (ROW_W+1)'(1) == (ROW_W+1)'(order_eff));
        q_entry.index   = IDX_W'(row_cur);
        q_entry.k       = K_W'(order_eff) - K_W'(row_cur) + K_W'(1);

        row_next = row_reg;
        orb_next = orb_reg;
        if (accept)
        begin
            if (row_end)
            begin
                orb_next = '0;
                row_next = (row_cur < ROW_W'(MAX_MOMENTS)) ? row_cur + ROW_W'(1) : row_cur;
            end
            else
            begin
                orb_next = orb_cur + ORB_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            orb_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            orb_reg <= orb_next;
        end
    end

endmodule

// ----- sv/jkmd_queue.sv -----
// Short FIFO between the front end and the arithmetic back end.
// Depends on jkmd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jkmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jkmd_pkg::q_entry_t   push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output jkmd_pkg::q_entry_t   head
);
    import jkmd_pkg::*;

    q_entry_t           mem [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next    = pop  ? rd_reg + QPTR_W'(1) : rd_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_entry;
    end

    `JKMD_NEVER(q_no_overrun, push && full)
    `JKMD_NEVER(q_no_underrun, pop && !head_valid)

endmodule

// ----- sv/jkmd_back.sv -----
// Back end: row weight, complex-by-real scaling and rotation recurrence,
// all on one shared 33x33 multiplier. Depends on jkmd_pkg, assert_macros.svh.
`include "assert_macros.svh"
module jkmd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jkmd_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  jkmd_pkg::q_entry_t   q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   damped_re,
    output logic signed [31:0]   damped_im,
    output logic [11:0]          moment_index,
    output logic                 last_kept
);
    import jkmd_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0_0000_0000_0001,
        ST_KPHI = 13'b0_0000_0000_0010,
        ST_ACOS = 13'b0_0000_0000_0100,
        ST_SCOT = 13'b0_0000_0000_1000,
        ST_WSUM = 13'b0_0000_0001_0000,
        ST_MRE  = 13'b0_0000_0010_0000,
        ST_MIM  = 13'b0_0000_0100_0000,
        ST_MOUT = 13'b0_0000_1000_0000,
        ST_ROT1 = 13'b0_0001_0000_0000,
        ST_ROT2 = 13'b0_0010_0000_0000,
        ST_ROT3 = 13'b0_0100_0000_0000,
        ST_ROT4 = 13'b0_1000_0000_0000,
        ST_ROT5 = 13'b1_0000_0000_0000
    } back_state_t;

    localparam logic signed [66:0] HALF = 67'sd536870912;

    back_state_t         state_reg, state_next;
    q_entry_t            work_reg, work_next;
    logic signed [65:0]  prod_reg, prod_next;
    logic signed [66:0]  acc_reg, acc_next;
    logic signed [31:0]  cos_reg, cos_next;
    logic signed [31:0]  sin_reg, sin_next;
    logic signed [31:0]  weight_reg, weight_next;
    logic signed [31:0]  cnew_reg, cnew_next;
    logic signed [31:0]  res_re_reg, res_re_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  dre_reg, dre_next;
    logic signed [31:0]  dim_reg, dim_next;
    logic [11:0]         idx_reg, idx_next;
    logic                last_reg, last_next;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [32:0]  a_sat;
    logic                mul_en, dispatch, out_free, out_load;
    logic signed [66:0]  prod_ext;

    // Round to nearest (half already added), shift out the fraction, saturate.
    function automatic logic signed [31:0] rnd_sat(input logic signed [66:0] v);
        logic signed [36:0] q;
        q = v[66:30];
        priority if (q > 37'sd2147483647)
            rnd_sat = 32'sh7FFF_FFFF;
        else if (q < -37'sd2147483648)
            rnd_sat = 32'sh8000_0000;
        else
            rnd_sat = q[31:0];
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign prod_ext = 67'(prod_reg);
    assign a_sat    = (prod_reg[65:31] != '0) ? 33'sd2147483647 : 33'(prod_reg[31:0]);

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        acc_next       = acc_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        weight_next    = weight_reg;
        cnew_next      = cnew_reg;
        res_re_next    = res_re_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dre_next       = dre_reg;
        dim_next       = dim_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        dispatch       = 1'b0;
        out_load       = 1'b0;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
                dispatch = 1'b1;
            ST_KPHI:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(work_reg.k);
                mul_b      = 33'(cfg.phi_over_pi);
                state_next = ST_ACOS;
            end
            ST_ACOS:
            begin
                mul_en     = 1'b1;
                mul_a      = a_sat;
                mul_b      = 33'(cos_reg);
                state_next = ST_SCOT;
            end
            ST_SCOT:
            begin
                acc_next   = prod_ext + HALF;
                mul_en     = 1'b1;
                mul_a      = 33'(sin_reg);
                mul_b      = 33'(cfg.cot_term);
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                weight_next = rnd_sat(acc_reg + prod_ext);
                state_next  = ST_MRE;
            end
            ST_MRE:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(work_reg.re);
                mul_b      = 33'(weight_reg);
                state_next = ST_MIM;
            end
            ST_MIM:
            begin
                res_re_next = rnd_sat(prod_ext + HALF);
                mul_en      = 1'b1;
                mul_a       = 33'(work_reg.im);
                mul_b       = 33'(weight_reg);
                state_next  = ST_MOUT;
            end
            ST_MOUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    dre_next       = res_re_reg;
                    dim_next       = rnd_sat(prod_ext + HALF);
                    idx_next       = work_reg.index;
                    last_next      = work_reg.last;
                    if (work_reg.row_end)
                        state_next = ST_ROT1;
                    else
                        dispatch = 1'b1;
                end
            end
            ST_ROT1:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(cos_reg);
                mul_b      = 33'(cfg.step_cos);
                state_next = ST_ROT2;
            end
            ST_ROT2:
            begin
                acc_next   = prod_ext + HALF;
                mul_en     = 1'b1;
                mul_a      = 33'(sin_reg);
                mul_b      = 33'(cfg.step_sin);
                state_next = ST_ROT3;
            end
            ST_ROT3:
            begin
                cnew_next  = rnd_sat(acc_reg - prod_ext);
                mul_en     = 1'b1;
                mul_a      = 33'(sin_reg);
                mul_b      = 33'(cfg.step_cos);
                state_next = ST_ROT4;
            end
            ST_ROT4:
            begin
                acc_next   = prod_ext + HALF;
                mul_en     = 1'b1;
                mul_a      = 33'(cos_reg);
                mul_b      = 33'(cfg.step_sin);
                state_next = ST_ROT5;
            end
            ST_ROT5:
            begin
                cos_next   = cnew_reg;
                sin_next   = rnd_sat(acc_reg + prod_ext);
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        // Take the next moment; mid-row moments start scaling at once.
        if (dispatch)
        begin
            state_next = ST_IDLE;
            if (q_valid)
            begin
                q_pop     = 1'b1;
                work_next = q_head;
                if (q_head.first)
                begin
                    cos_next = Q_ONE;
                    sin_next = '0;
                end
                if (q_head.orb0)
                    state_next = ST_KPHI;
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = 33'(q_head.re);
                    mul_b      = 33'(weight_reg);
                    state_next = ST_MIM;
                end
            end
        end

        prod_next = mul_en ? mul_a * mul_b : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cos_reg       <= Q_ONE;
            sin_reg       <= '0;
            weight_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
            weight_reg    <= weight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        cnew_reg   <= cnew_next;
        res_re_reg <= res_re_next;
        dre_reg    <= dre_next;
        dim_reg    <= dim_next;
        idx_reg    <= idx_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign damped_re    = dre_reg;
    assign damped_im    = dim_reg;
    assign moment_index = idx_reg;
    assign last_kept    = last_reg;

    `JKMD_ASSERT(back_pop_when_dispatching, q_pop |-> (state_reg == ST_IDLE || state_reg == ST_MOUT))
    `JKMD_ASSERT(back_load_into_free_slot, out_load |-> (!out_valid_reg || out_ready))

endmodule

// ----- sv/jackson_kernel_moment_damping_unit.sv -----
// Top level of the Jackson kernel moment damping unit: APB registers,
// front end, queue and back end. Depends on jkmd_pkg and the jkmd_* modules.
//
// Usage:
//   Moments enter on the in_valid/in_ready channel, one complex value per
//   transaction, row by row (all orbitals of moment m, then m+1). Raise
//   first_item with moment 0, orbital 0 to restart the row count and the
//   cos/sin recurrence. Rows at or beyond kernel_order are dropped with no
//   result; kept moments leave on out_valid/out_ready scaled by the Jackson
//   weight of their row, moment_index on each, last_kept on the final one.
//   Each mid-row moment makes two passes through the shared multiplier (real
//   part, then imaginary part). The first orbital of a row first builds the
//   row weight, and the end of a kept row adds the four rotation products.
//   A four-entry queue parts the front from the back, so the input keeps
//   flowing while the back works or the receiver stalls; a stalled receiver
//   holds the result register, then the back, then the queue fills and
//   in_ready drops. Reset (rst_n low) restores the register defaults and
//   clears the counters and the recurrence; write registers only when idle.
module jackson_kernel_moment_damping_unit (
    input  logic                clk,
    input  logic                rst_n,
    // APB-style configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // moment input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  moment_re,
    input  logic signed [31:0]  moment_im,
    input  logic                first_item,
    // damped result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  damped_re,
    output logic signed [31:0]  damped_im,
    output logic [11:0]         moment_index,
    output logic                last_kept
);
    import jkmd_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      cfg_write;
    logic      q_full, q_push, q_pop, q_valid;
    q_entry_t  q_in, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register writes land on the access cycle; unknown addresses are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_KERNEL_ORDER:  cfg_next.kernel_order  = pwdata[ORDER_W-1:0];
                REG_ORBITAL_COUNT: cfg_next.orbital_count = pwdata[COUNT_W-1:0];
                REG_PHI_OVER_PI:   cfg_next.phi_over_pi   = pwdata[30:0];
                REG_COT_TERM:      cfg_next.cot_term      = pwdata[30:0];
                REG_STEP_COS:      cfg_next.step_cos      = pwdata;
                REG_STEP_SIN:      cfg_next.step_sin      = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_order  <= ORDER_W'(1);
            cfg_reg.orbital_count <= COUNT_W'(1);
            cfg_reg.phi_over_pi   <= 31'h2000_0000;
            cfg_reg.cot_term      <= '0;
            cfg_reg.step_cos      <= '0;
            cfg_reg.step_sin      <= Q_ONE;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Read back the addressed register, zero-extended.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_KERNEL_ORDER:  prdata = 32'(cfg_reg.kernel_order);
            REG_ORBITAL_COUNT: prdata = 32'(cfg_reg.orbital_count);
            REG_PHI_OVER_PI:   prdata = 32'(cfg_reg.phi_over_pi);
            REG_COT_TERM:      prdata = 32'(cfg_reg.cot_term);
            REG_STEP_COS:      prdata = cfg_reg.step_cos;
            REG_STEP_SIN:      prdata = cfg_reg.step_sin;
            default:           prdata = '0;
        endcase
    end

    // Classify each moment: count rows and orbitals, drop truncated rows.
    jkmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .moment_re  (moment_re),
        .moment_im  (moment_im),
        .first_item (first_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    // Hold kept moments until the back end is free.
    jkmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Weight, scale and rotate on the shared multiplier.
    jkmd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .damped_re    (damped_re),
        .damped_im    (damped_im),
        .moment_index (moment_index),
        .last_kept    (last_kept)
    );

endmodule

// ----- test/tb_jackson_kernel_moment_damping_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the Jackson kernel moment damping unit: streams moment rows,
// predicts each damped result in a scoreboard class and compares it on arrival.
// Depends on jkmd_pkg and jackson_kernel_moment_damping_unit.

import jkmd_pkg::*;

typedef enum int
{
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
} ready_mode_t;

typedef struct
{
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [11:0]        index;
    logic               last;
} damped_t;

class damping_scoreboard;
    // register copies, held as the block masks them
    int     order_reg;
    int     count_reg;
    longint phi_reg;
    longint cot_reg;
    longint cos_step;
    longint sin_step;
    // row bookkeeping and the cos/sin recurrence
    int     row_ctr;
    int     orb_ctr;
    longint cos_run;
    longint sin_run;
    longint weight;
    int     errors;
    damped_t expected_damped[$];

    function new();
        order_reg = 1;
        count_reg = 1;
        phi_reg   = 64'sd536870912;
        cot_reg   = 0;
        cos_step  = 0;
        sin_step  = 64'sd1073741824;
        row_ctr   = 0;
        orb_ctr   = 0;
        cos_run   = 64'sd1073741824;
        sin_run   = 0;
        weight    = 0;
        errors    = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] value);
        case (idx)
            REG_KERNEL_ORDER:  order_reg = int'(value[12:0]);
            REG_ORBITAL_COUNT: count_reg = int'(value[8:0]);
            REG_PHI_OVER_PI:   phi_reg = longint'(value[30:0]);
            REG_COT_TERM:      cot_reg = longint'(value[30:0]);
            REG_STEP_COS:      cos_step = $signed(value);
            REG_STEP_SIN:      sin_step = $signed(value);
            default: ;
        endcase
    endfunction

    // Round (p1 + p2) / 2^30 to nearest, ties upward, with one rounding; clip to 32 bits.
    function longint round_q30(longint p1, longint p2);
        longint r1;
        longint r2;
        longint q;
        r1 = p1 & 64'sh3FFF_FFFF;
        r2 = p2 & 64'sh3FFF_FFFF;
        q = (p1 >>> 30) + (p2 >>> 30) + ((r1 + r2 + 64'sd536870912) >>> 30);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    // Advance the row state by one accepted moment; queue its damped value if the row is kept.
    function bit note_moment(logic signed [31:0] re, logic signed [31:0] im, logic first);
        int      order;
        int      norb;
        bit      kept;
        bit      row_end;
        longint  a;
        longint  c;
        longint  s;
        damped_t want;
        order = (order_reg == 0) ? 1 : ((order_reg > MAX_MOMENTS) ? MAX_MOMENTS : order_reg);
        norb  = (count_reg == 0) ? 1 : ((count_reg > MAX_ORBITALS) ? MAX_ORBITALS : count_reg);
        if (first)
        begin
            row_ctr = 0;
            orb_ctr = 0;
            cos_run = 64'sd1073741824;
            sin_run = 0;
        end
        if (orb_ctr >= norb)
            orb_ctr = 0;
        kept    = row_ctr < order;
        row_end = (orb_ctr + 1) >= norb;
        if (kept)
        begin
            if (orb_ctr == 0)
            begin
                a = longint'(order - row_ctr + 1) * phi_reg;
                if (a > 64'sd2147483647)
                    a = 64'sd2147483647;
                weight = round_q30(a * cos_run, sin_run * cot_reg);
            end
            want.re    = 32'(round_q30(longint'(re) * weight, 0));
            want.im    = 32'(round_q30(longint'(im) * weight, 0));
            want.index = 12'(row_ctr);
            want.last  = row_end && (row_ctr + 1 == order);
            expected_damped.push_back(want);
        end
        if (row_end)
        begin
            if (kept)
            begin
                c = cos_run;
                s = sin_run;
                cos_run = round_q30(c * cos_step, -(s * sin_step));
                sin_run = round_q30(s * cos_step, c * sin_step);
            end
            orb_ctr = 0;
            if (row_ctr < MAX_MOMENTS)
                row_ctr++;
        end
        else
            orb_ctr++;
        return kept;
    endfunction

    function void check_damped(logic signed [31:0] re, logic signed [31:0] im,
                               logic [11:0] idx, logic last);
        damped_t want;
        if (expected_damped.size() == 0)
        begin
            $error("damped result with none expected: re %0d im %0d index %0d", re, im, idx);
            errors++;
        end
        else
        begin
            want = expected_damped.pop_front();
            if (re !== want.re)
            begin
                $error("damped_re: expected %0d, got %0d", want.re, re);
                errors++;
            end
            if (im !== want.im)
            begin
                $error("damped_im: expected %0d, got %0d", want.im, im);
                errors++;
            end
            if (idx !== want.index)
            begin
                $error("moment_index: expected %0d, got %0d", want.index, idx);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_kept: expected %0d, got %0d", want.last, last);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_damped.size();
    endfunction
endclass

module tb_jackson_kernel_moment_damping_unit;

    localparam real PI        = 3.14159265358979323846;
    localparam real Q30_SCALE = 1073741824.0;

    // Quiet cycles allowed before the run is declared hung; well above the long hold-off.
    localparam int WATCHDOG_LIMIT    = 4000;
    // Cycles to let a row-weight build or rotation finish after the last result.
    localparam int SETTLE_CYCLES     = 64;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS      = 1490;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] moment_re;
    logic signed [31:0] moment_im;
    logic               first_item;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] damped_re;
    logic signed [31:0] damped_im;
    logic [11:0]        moment_index;
    logic               last_kept;

    damping_scoreboard sb = new();

    // sender burst state and the count of moments sent in the random part
    int burst_left;
    int sent_items;
    // raised once by the stimulus to ask the receiver for its long hold-off
    bit long_hold_armed = 1'b0;

    always #5 clk = ~clk;

    jackson_kernel_moment_damping_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .moment_re    (moment_re),
        .moment_im    (moment_im),
        .first_item   (first_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .damped_re    (damped_re),
        .damped_im    (damped_im),
        .moment_index (moment_index),
        .last_kept    (last_kept)
    );

    // Words that favour the corners of the 32-bit range.
    function automatic logic [31:0] biased_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h4000_0000;
            5: return 32'hC000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly moments within +/-0.5 as a real expansion gives, the rest anywhere.
    function automatic logic [31:0] random_moment();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 4) < 3)
            return {{2{w[29]}}, w[29:0]};
        return biased_word();
    endfunction

    // Register values as the host would derive them for order M: phi = pi / (M + 1).
    function automatic cfg_t jackson_settings(int order_field, int norb_field);
        cfg_t s;
        int   m;
        real  phi;
        m = (order_field == 0) ? 1 : ((order_field > MAX_MOMENTS) ? MAX_MOMENTS : order_field);
        phi = PI / (m + 1);
        s.kernel_order  = 13'(order_field);
        s.orbital_count = 9'(norb_field);
        s.phi_over_pi   = 31'($rtoi(Q30_SCALE / (m + 1) + 0.5));
        s.cot_term      = 31'($rtoi($cos(phi) / $sin(phi) * phi / PI * Q30_SCALE + 0.5));
        s.step_cos      = 32'($rtoi($cos(phi) * Q30_SCALE + 0.5));
        s.step_sin      = 32'($rtoi($sin(phi) * Q30_SCALE + 0.5));
        return s;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.kernel_order  = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40));
        s.orbital_count = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 6));
        s.phi_over_pi   = 31'(biased_word());
        s.cot_term      = 31'(biased_word());
        s.step_cos      = biased_word();
        s.step_sin      = biased_word();
        return s;
    endfunction

    // Present one moment and hold it until the transaction completes. Bursts of
    // random length are broken by random gaps; note the moment once accepted.
    task automatic send_moment(input logic [31:0] re, input logic [31:0] im,
                               input logic first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        moment_re  <= re;
        moment_im  <= im;
        first_item <= first;
        do
            @(posedge clk);
        while (!in_ready);
        void'(sb.note_moment(re, im, first));
        sent_items++;
    endtask

    // Drop valid, wait for every outstanding result, then let the back end finish
    // any rotation still under way.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then back to idle before the next write.
    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        settle();
        write_register(REG_KERNEL_ORDER, 32'(s.kernel_order));
        write_register(REG_ORBITAL_COUNT, 32'(s.orbital_count));
        write_register(REG_PHI_OVER_PI, 32'(s.phi_over_pi));
        write_register(REG_COT_TERM, 32'(s.cot_term));
        write_register(REG_STEP_COS, s.step_cos);
        write_register(REG_STEP_SIN, s.step_sin);
    endtask

    // Well-formed expansions: first_item on moment 0, rows up to and a little past
    // the order, random content. Now and then raise first_item mid-stream, cut a
    // pass short or pause until the block has drained.
    task automatic jackson_phase();
        int order_field;
        int norb_field;
        int m;
        int norb;
        int total;
        int cut;
        int i;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: order_field = $urandom_range(1, 10);
            7, 8:                order_field = $urandom_range(11, 64);
            default:
                case ($urandom_range(0, 2))
                    0:       order_field = 0;
                    1:       order_field = MAX_MOMENTS;
                    default: order_field = $urandom_range(MAX_MOMENTS + 1, 8191);
                endcase
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: norb_field = $urandom_range(1, 4);
            6, 7:             norb_field = $urandom_range(5, 16);
            8:                norb_field = $urandom_range(17, 255);
            default:
                case ($urandom_range(0, 2))
                    0:       norb_field = 0;
                    1:       norb_field = MAX_ORBITALS;
                    default: norb_field = $urandom_range(MAX_ORBITALS + 1, 511);
                endcase
        endcase
        apply_settings(jackson_settings(order_field, norb_field));
        m = (order_field == 0) ? 1 : ((order_field > MAX_MOMENTS) ? MAX_MOMENTS : order_field);
        norb = (norb_field == 0) ? 1 : ((norb_field > MAX_ORBITALS) ? MAX_ORBITALS : norb_field);
        repeat ($urandom_range(1, 3))
        begin
            total = (m + $urandom_range(0, 2)) * norb;
            if (total > 150)
                total = 150;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
            for (i = 0; i < cut; i++)
                send_moment(random_moment(), random_moment(),
                            (i == 0) || ($urandom_range(0, 59) == 0));
            if ($urandom_range(0, 5) == 0)
                settle();
        end
    endtask

    // Arbitrary register values; the stream often carries on from the old counters.
    task automatic scramble_phase();
        int i;
        int count;
        apply_settings(random_settings());
        count = $urandom_range(20, 80);
        for (i = 0; i < count; i++)
            send_moment(random_moment(), random_moment(), $urandom_range(0, 7) == 0);
    endtask

    // Compare every result transaction as it completes.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_damped(damped_re, damped_im, moment_index, last_kept);
    end

    // Receiver: switch between stall patterns every so often, and take one long
    // hold-off when asked so that the queue fills and in_ready drops.
    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        bit          hold_taken;
        out_ready  = 1'b0;
        mode       = READY_ALWAYS;
        mode_left  = 0;
        hold_left  = 0;
        tick       = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: out_ready <= (tick % 5 == 0);
                    default:      out_ready <= ((tick / 3) % 2 == 0);
                endcase
        end
    end

    // Watchdog: end the run if no transaction completes on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("jackson_kernel_moment_damping_unit regression: fail");
        $finish;
    end

    initial
    begin
        cfg_t settings;
        int   i;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        moment_re  = '0;
        moment_im  = '0;
        first_item = 1'b0;
        burst_left = 0;
        sent_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings give a unit weight on row 0 and drop every later row:
        // drive the corners of both moment fields through it.
        send_moment(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_moment(32'h1234_5678, 32'h8765_4321, 1'b0);
        send_moment(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_moment(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_moment(32'h0000_0001, 32'hC000_0000, 1'b1);

        // Zero order and zero orbitals act as one; full-scale terms saturate the
        // weight, the products and the rotation.
        settings = '{kernel_order: 13'd0, orbital_count: 9'd0,
                     phi_over_pi: 31'h7FFF_FFFF, cot_term: 31'h7FFF_FFFF,
                     step_cos: 32'sh8000_0000, step_sin: 32'sh7FFF_FFFF};
        apply_settings(settings);
        send_moment(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_moment(32'h4000_0000, 32'hC000_0000, 1'b0);
        send_moment(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_moment(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);

        // Order and orbital count above their ceilings clamp to the maxima.
        settings = '{kernel_order: 13'h1FFF, orbital_count: 9'h1FF,
                     phi_over_pi: 31'h0000_0001, cot_term: 31'h7FFF_FFFF,
                     step_cos: 32'sh7FFF_FFFF, step_sin: 32'sh8000_0000};
        apply_settings(settings);
        send_moment(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        for (i = 0; i < 3; i++)
            send_moment(biased_word(), biased_word(), 1'b0);

        // Stop partway into a row, shrink the orbital count below the position
        // reached, then carry on without first_item: the row restarts at orbital 0.
        apply_settings(jackson_settings(4, 5));
        for (i = 0; i < 8; i++)
            send_moment(random_moment(), random_moment(), i == 0);
        settle();
        write_register(REG_ORBITAL_COUNT, 32'd2);
        for (i = 0; i < 3; i++)
            send_moment(random_moment(), random_moment(), 1'b0);

        // Hold the receiver off for a long stretch while moments keep coming.
        apply_settings(jackson_settings(12, 3));
        long_hold_armed = 1'b1;
        for (i = 0; i < 40; i++)
            send_moment(random_moment(), random_moment(), i == 0);

        // Random part: mostly well-formed expansions, the rest scrambled settings.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                jackson_phase();
            else
                scramble_phase();
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("jackson_kernel_moment_damping_unit regression: pass");
        else
            $display("jackson_kernel_moment_damping_unit regression: fail");
        $finish;
    end

endmodule

// ----- jackson_kernel_moment_damping_unit.f -----
+incdir+sv
sv/jkmd_pkg.sv
sv/jkmd_front.sv
sv/jkmd_queue.sv
sv/jkmd_back.sv
sv/jackson_kernel_moment_damping_unit.sv
test/tb_jackson_kernel_moment_damping_unit.sv
